// ===== rtl/assert_macros.svh =====
// assertion macros for the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LUD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder check failed");

// next-cycle implication, disabled while reset is low
`define LUD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder check failed");

`endif

// ===== rtl/lud_pkg.sv =====
// shared types and constants of the lenient utf-8 decoder
package lud_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;

  localparam logic [ByteW-1:0] Lead4Min  = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Min  = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Min  = 8'hC0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'h07;
  localparam logic [ByteW-1:0] Lead3Mask = 8'h0F;
  localparam logic [ByteW-1:0] Lead2Mask = 8'h1F;
  localparam logic [ByteW-1:0] ContTag   = 8'h80;
  localparam logic [ByteW-1:0] ContMask  = 8'h3F;
  localparam logic [ByteW-1:0] TagMask   = 8'hC0;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           last_of_item;
  } result_t;

  typedef struct packed {
    logic [CpW-1:0] partial_value;
    logic [1:0]     bytes_left;
  } dec_state_t;

  typedef struct packed {
    logic [1:0] nres;
    result_t    res0;
    result_t    res1;
    dec_state_t next;
  } step_t;

  typedef struct packed {
    logic [1:0] free;
  } buf_stat_t;

endpackage

// ===== rtl/lud_if.sv =====
// request channels of the decoder: text bytes in, code points out
interface lud_byte_if;
  logic                     valid;
  logic                     ready;
  logic [lud_pkg::ByteW-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface lud_cp_if;
  logic                    valid;
  logic                    ready;
  logic [lud_pkg::CpW-1:0] code_point;
  logic                    last_of_item;

  modport source (output valid, output code_point, output last_of_item, input ready);
  modport sink (input valid, input code_point, input last_of_item, output ready);
endinterface

// ===== rtl/lenient_utf8_decoder.sv =====
// top level of the lenient utf-8 decoder: input register, decode step, result buffer
// Takes one text byte per request on in_i and returns code points on out_o, one
// per request, with last_of_item marking the final code point caused by a byte.
// A byte may be taken every clock cycle. A byte is held in the input register,
// decoded from there against the held state and, once the buffer has room for
// all of them, drops its zero, one or two results into a two-entry result buffer,
// whose registered slots offer the first result on out_o. The buffer hands out
// one code point per cycle while the receiver is ready, so bytes with two code
// points, such as a plain byte that cuts a sequence, drain more slowly than they
// come in; sustained rate is one byte per cycle otherwise. When the receiver holds
// off, the buffer and the input register fill up and the input stalls until room
// frees up. No validation is done: overlong forms, surrogates and values above
// 0x10ffff pass through, and byte zero ends the text, flushing any partial value.
`include "assert_macros.svh"

module lenient_utf8_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  lud_byte_if.sink  in_i,
  lud_cp_if.source  out_o
);

  // input register
  logic [lud_pkg::ByteW-1:0] byte_q;
  logic                      byte_vld_q, byte_vld_d;

  // decoder state: partial value and continuation bytes still awaited
  lud_pkg::dec_state_t state_q;

  lud_pkg::step_t     step;
  lud_pkg::buf_stat_t buf_stat;
  logic               take;
  logic [1:0]         push_n;

  lud_step u_step (
    .byte_i  (byte_q),
    .state_i (state_q),
    .step_o  (step)
  );

  // the held byte moves on once the buffer has room for all of its results
  assign take   = byte_vld_q && (step.nres <= buf_stat.free);
  assign push_n = take ? step.nres : 2'd0;

  assign in_i.ready = !byte_vld_q || take;

  always_comb begin
    byte_vld_d = byte_vld_q;
    if (in_i.valid && in_i.ready) begin
      byte_vld_d = 1'b1;
    end else if (take) begin
      byte_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
      state_q    <= '0;
    end else begin
      byte_vld_q <= byte_vld_d;
      if (take) begin
        state_q <= step.next;
      end
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.text_byte;
    end
  end

  lud_res_buf u_res_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (step.res0),
    .push1_i  (step.res1),
    .stat_o   (buf_stat),
    .out_o    (out_o)
  );

  // with no sequence pending the partial value is always clear
  `LUD_ASSERT_IMPL(a_idle_clear, clk_i, rst_ni, state_q.bytes_left == 2'd0,
                   state_q.partial_value == '0)
  // after a four-byte lead only its three payload bits are held
  `LUD_ASSERT_IMPL(a_left3_narrow, clk_i, rst_ni, state_q.bytes_left == 2'd3,
                   state_q.partial_value[lud_pkg::CpW-1:3] == '0)
  // with two continuation bytes left at most nine bits are held
  `LUD_ASSERT_IMPL(a_left2_narrow, clk_i, rst_ni, state_q.bytes_left == 2'd2,
                   state_q.partial_value[lud_pkg::CpW-1:9] == '0)

endmodule

// ===== rtl/lud_step.sv =====
// per-byte classify, shift and emit step of the decoder
module lud_step (
  input  logic [lud_pkg::ByteW-1:0] byte_i,
  input  lud_pkg::dec_state_t       state_i,
  output lud_pkg::step_t            step_o
);

  logic                    pending;
  logic                    is_cont;
  logic [lud_pkg::CpW-1:0] shifted;
  logic [1:0]              left_dec;

  assign pending  = (state_i.bytes_left != 2'd0);
  assign is_cont  = ((byte_i & lud_pkg::TagMask) == lud_pkg::ContTag);
  assign shifted  = {state_i.partial_value[lud_pkg::CpW-7:0], byte_i[5:0]};
  assign left_dec = state_i.bytes_left - 2'd1;

  always_comb begin
    step_o                    = '0;
    step_o.res0.code_point    = state_i.partial_value;
    step_o.res0.last_of_item  = 1'b1;
    step_o.res1.code_point    = {{(lud_pkg::CpW-lud_pkg::ByteW){1'b0}}, byte_i};
    step_o.res1.last_of_item  = 1'b1;
    if (byte_i == '0) begin
      // end of text: flush any partial value, clear state
      step_o.nres = {1'b0, pending};
    end else if (pending && is_cont) begin
      if (left_dec == 2'd0) begin
        step_o.nres            = 2'd1;
        step_o.res0.code_point = shifted;
      end else begin
        step_o.next.partial_value = shifted;
        step_o.next.bytes_left    = left_dec;
      end
    end else begin
      // cut sequence flushes first, then the byte starts afresh
      step_o.res0.last_of_item = 1'b0;
      if (byte_i >= lud_pkg::Lead2Min) begin
        step_o.res0.last_of_item = 1'b1;
        step_o.nres              = {1'b0, pending};
        priority if (byte_i >= lud_pkg::Lead4Min) begin
          step_o.next.partial_value = lud_pkg::CpW'(byte_i & lud_pkg::Lead4Mask);
          step_o.next.bytes_left    = 2'd3;
        end else if (byte_i >= lud_pkg::Lead3Min) begin
          step_o.next.partial_value = lud_pkg::CpW'(byte_i & lud_pkg::Lead3Mask);
          step_o.next.bytes_left    = 2'd2;
        end else begin
          step_o.next.partial_value = lud_pkg::CpW'(byte_i & lud_pkg::Lead2Mask);
          step_o.next.bytes_left    = 2'd1;
        end
      end else if (pending) begin
        step_o.nres = 2'd2;
      end else begin
        step_o.nres = 2'd1;
        step_o.res0 = step_o.res1;
      end
    end
  end

endmodule

// ===== rtl/lud_res_buf.sv =====
// two-entry result buffer that takes up to two results per cycle
module lud_res_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_n_i,
  input  lud_pkg::result_t    push0_i,
  input  lud_pkg::result_t    push1_i,
  output lud_pkg::buf_stat_t  stat_o,
  lud_cp_if.source            out_o
);

  lud_pkg::result_t slot_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.code_point   = slot_q[rd_q].code_point;
  assign out_o.last_of_item = slot_q[rd_q].last_of_item;
  assign pop                = out_o.valid && out_o.ready;

  assign stat_o.free = 2'd2 - cnt_q + {1'b0, pop};

  assign wr_d  = wr_q ^ push_n_i[0];
  assign rd_d  = rd_q ^ pop;
  assign cnt_d = cnt_q + push_n_i - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      slot_q[wr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      slot_q[~wr_q] <= push1_i;
    end
  end

endmodule

// ===== test/lenient_utf8_decoder_test.sv =====
// testbench of the lenient utf-8 decoder: directed and random byte streams checked per code point
module lenient_utf8_decoder_test;

  // receiver hold-off long enough to fill the input register and the result buffer
  localparam int unsigned HoldOffCycles = 60;
  // cycles without any request before the run is declared hung
  localparam int unsigned StallLimit    = 1000;
  // idle margin at the end of the run, after all code points are back
  localparam int unsigned SettleCycles  = 10;
  localparam int unsigned PhaseBytes    = 600;
  localparam int unsigned PressureBytes = 200;

  // directed text: plain bytes, a stray continuation, each lead length at the top of
  // its range and the two- and four-byte leads at the bottom, a sequence cut by a
  // plain byte, one cut by a new lead, and a sequence ended early by the end-of-text byte
  localparam int unsigned DirectedLen = 28;
  localparam logic [lud_pkg::ByteW-1:0] DirectedText [DirectedLen] = '{
    8'h00, 8'h01, 8'h7F, 8'h80,
    8'hC0, 8'h80,
    8'hDF, 8'hBF,
    8'hEF, 8'hBF, 8'hBF,
    8'hF0, 8'h80, 8'h80, 8'h80,
    8'hFF, 8'hBF, 8'hBF, 8'hBF,
    8'hE2, 8'h41,
    8'hE2, 8'h82, 8'hC3, 8'hA9,
    8'hF4, 8'h90, 8'h00
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  lud_byte_if byte_ch ();
  lud_cp_if   cp_ch ();

  lenient_utf8_decoder u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_ch),
    .out_o (cp_ch)
  );

  // bytes waiting for the driver, code points the decoder still owes us
  logic [lud_pkg::ByteW-1:0] bytes_to_send[$];
  lud_pkg::result_t          code_points_due[$];

  // predictor state: value being assembled and continuation bytes still owed
  logic [lud_pkg::CpW-1:0] held_value  = '0;
  logic [1:0]              conts_owed  = 2'd0;

  int unsigned send_idle_pct     = 0;
  int unsigned recv_idle_pct     = 0;
  int unsigned hold_off_requests = 0;
  int unsigned hold_off_served   = 0;
  int unsigned hold_off_left     = 0;
  int unsigned quiet_cycles      = 0;
  int unsigned mismatches        = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic lud_pkg::result_t code_point_of(input logic [lud_pkg::CpW-1:0] cp,
                                                     input logic last);
    lud_pkg::result_t r;
    r.code_point   = cp;
    r.last_of_item = last;
    return r;
  endfunction

  // append one expected code point
  task automatic add_due(input lud_pkg::result_t r);
    code_points_due = {code_points_due, r};
  endtask

  // append one byte for the driver
  task automatic add_byte(input logic [lud_pkg::ByteW-1:0] b);
    bytes_to_send = {bytes_to_send, b};
  endtask

  // predictor: one text byte in, zero to two code points appended to the expectations
  task automatic decode_text_byte(input logic [lud_pkg::ByteW-1:0] b);
    logic [lud_pkg::CpW-1:0] cut_value;
    logic                    was_cut;
    was_cut   = 1'b0;
    cut_value = '0;
    if (b == '0) begin
      // end of text flushes whatever is pending
      if (conts_owed != 2'd0) add_due(code_point_of(held_value, 1'b1));
      held_value = '0;
      conts_owed = 2'd0;
    end else if (conts_owed != 2'd0 && (b & lud_pkg::TagMask) == lud_pkg::ContTag) begin
      // continuation byte shifts in six more bits
      held_value = (held_value << 6) | lud_pkg::CpW'(b & lud_pkg::ContMask);
      conts_owed = conts_owed - 2'd1;
      if (conts_owed == 2'd0) begin
        add_due(code_point_of(held_value, 1'b1));
        held_value = '0;
      end
    end else begin
      // a non-continuation byte cuts a pending sequence short
      if (conts_owed != 2'd0) begin
        was_cut    = 1'b1;
        cut_value  = held_value;
        held_value = '0;
        conts_owed = 2'd0;
      end
      if (b >= lud_pkg::Lead2Min) begin
        // lead byte: nothing of its own, so a cut value is the last result
        if (b >= lud_pkg::Lead4Min) begin
          held_value = lud_pkg::CpW'(b & lud_pkg::Lead4Mask);
          conts_owed = 2'd3;
        end else if (b >= lud_pkg::Lead3Min) begin
          held_value = lud_pkg::CpW'(b & lud_pkg::Lead3Mask);
          conts_owed = 2'd2;
        end else begin
          held_value = lud_pkg::CpW'(b & lud_pkg::Lead2Mask);
          conts_owed = 2'd1;
        end
        if (was_cut) add_due(code_point_of(cut_value, 1'b1));
      end else begin
        // plain byte or stray continuation passes through as a code point
        if (was_cut) add_due(code_point_of(cut_value, 1'b0));
        add_due(code_point_of(lud_pkg::CpW'(b), 1'b1));
      end
    end
  endtask

  // random text, mostly well-formed sequences with random payload bits
  task automatic queue_random_text(input int unsigned n_bytes);
    int unsigned added;
    int unsigned pick;
    int unsigned conts;
    int unsigned k;
    logic [lud_pkg::ByteW-1:0] lead;
    added = 0;
    while (added < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        conts = $urandom_range(3);
        case (conts)
          0: lead = lud_pkg::ByteW'($urandom_range(8'h7F, 8'h01));
          1: lead = lud_pkg::ByteW'($urandom_range(8'hDF, 8'hC0));
          2: lead = lud_pkg::ByteW'($urandom_range(8'hEF, 8'hE0));
          default: lead = lud_pkg::ByteW'($urandom_range(8'hFF, 8'hF0));
        endcase
        add_byte(lead);
        added++;
        // broken sequence: too few continuations for its lead
        if (pick >= 60 && conts != 0) conts = $urandom_range(conts - 1);
        for (k = 0; k < conts; k++) begin
          add_byte(lud_pkg::ByteW'($urandom_range(8'hBF, 8'h80)));
          added++;
        end
      end else if (pick < 85) begin
        add_byte(lud_pkg::ByteW'($urandom_range(8'hBF, 8'h80)));
        added++;
      end else if (pick < 93) begin
        add_byte('0);
        added++;
      end else begin
        add_byte(lud_pkg::ByteW'($urandom_range(8'hFF, 8'h00)));
        added++;
      end
    end
  endtask

  // sender pause: nothing more goes out until every code point has come back
  task automatic wait_all_decoded();
    while (bytes_to_send.size() != 0 || byte_ch.valid || code_points_due.size() != 0)
      @(negedge clk_i);
  endtask

  // driver: a new byte is offered only once the previous one was taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_ch.valid     <= 1'b0;
      byte_ch.text_byte <= '0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) decode_text_byte(byte_ch.text_byte);
      if (!byte_ch.valid || byte_ch.ready) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          byte_ch.valid     <= 1'b1;
          byte_ch.text_byte <= bytes_to_send.pop_front();
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: every code point request is checked against the oldest expectation,
  // ready is thrown at random or held low for a long stretch on request
  always @(posedge clk_i or negedge rst_ni) begin
    lud_pkg::result_t due;
    if (!rst_ni) begin
      cp_ch.ready <= 1'b0;
    end else begin
      if (cp_ch.valid && cp_ch.ready) begin
        if (code_points_due.size() == 0) begin
          $display("%0t: expected no code point, got 0x%06h last %0b", $time,
                   cp_ch.code_point, cp_ch.last_of_item);
          mismatches++;
        end else begin
          due = code_points_due.pop_front();
          if (cp_ch.code_point !== due.code_point) begin
            $display("%0t: code_point expected 0x%06h, got 0x%06h", $time,
                     due.code_point, cp_ch.code_point);
            mismatches++;
          end
          if (cp_ch.last_of_item !== due.last_of_item) begin
            $display("%0t: last_of_item expected %0b, got %0b", $time,
                     due.last_of_item, cp_ch.last_of_item);
            mismatches++;
          end
        end
      end
      if (hold_off_served != hold_off_requests) begin
        hold_off_served <= hold_off_requests;
        hold_off_left   <= HoldOffCycles;
        cp_ch.ready     <= 1'b0;
      end else if (hold_off_left != 0) begin
        hold_off_left <= hold_off_left - 1;
        cp_ch.ready   <= 1'b0;
      end else begin
        cp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: too long without any request on either side means a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (cp_ch.valid && cp_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("%0t: no request for %0d cycles", $time, quiet_cycles);
        $display("** lenient_utf8_decoder: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // slow receiver, directed text first
    send_idle_pct = 29;
    recv_idle_pct = 75;
    for (int i = 0; i < DirectedLen; i++) add_byte(DirectedText[i]);
    wait_all_decoded();
    queue_random_text(PhaseBytes);
    wait_all_decoded();

    // slow sender
    send_idle_pct = 75;
    recv_idle_pct = 29;
    queue_random_text(PhaseBytes);
    wait_all_decoded();

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_text(PhaseBytes);
    wait_all_decoded();

    // back pressure: receiver holds off while bytes keep coming
    queue_random_text(PressureBytes);
    hold_off_requests = hold_off_requests + 1;
    wait_all_decoded();

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** lenient_utf8_decoder: PASSED **");
    end else begin
      $display("** lenient_utf8_decoder: FAILED **");
    end
    $finish;
  end

endmodule
